// ===== design/ledt_pkg.sv =====
`default_nettype none

package ledt_pkg;

    localparam int LINE_CAPACITY = 127;
    localparam int MAX_TOKENS    = 8;

    localparam int FILL_W  = $clog2(LINE_CAPACITY + 1);
    localparam int ADDR_W  = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam int COUNT_W = $clog2(MAX_TOKENS + 1);
    localparam int IDX_W   = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

    // fixed result field widths
    localparam int CHAR_W   = 8;
    localparam int KIND_W   = 3;
    localparam int ERASE_W  = 7;
    localparam int TCOUNT_W = 4;
    localparam int TINDEX_W = 3;
    localparam int TSTART_W = 7;
    localparam int TLEN_W   = 7;

    localparam logic [KIND_W-1:0] K_ECHO   = 3'd0;
    localparam logic [KIND_W-1:0] K_ERASE  = 3'd1;
    localparam logic [KIND_W-1:0] K_LINE   = 3'd2;
    localparam logic [KIND_W-1:0] K_CANCEL = 3'd3;
    localparam logic [KIND_W-1:0] K_TOKEN  = 3'd4;

    localparam logic [CHAR_W-1:0] CH_ETX   = 8'h03;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_EOL,
        C_CANCEL,
        C_KILL,
        C_BS,
        C_NOT_STORABLE,
        C_FILL_ZERO,
        C_SCAN_END,
        C_SPACE,
        C_POS_END,
        C_IDX_DONE
    } t_cond;

    typedef enum logic [2:0] {
        E_NONE,
        E_ECHO,
        E_KILL,
        E_BS,
        E_CANCEL,
        E_LINE,
        E_TOKEN
    } t_emit;

    typedef enum logic [1:0] {
        F_HOLD,
        F_INC,
        F_DEC,
        F_CLR
    } t_fill_op;

    typedef enum logic [1:0] {
        P_HOLD,
        P_CLR,
        P_INC
    } t_pos_op;

    typedef enum logic [1:0] {
        I_HOLD,
        I_CLR,
        I_INC
    } t_idx_op;

    typedef struct packed {
        logic     in_ready;
        logic     wr_en;
        logic     tok_start;
        logic     tok_save;
        logic     scan_clr;
        t_fill_op fill_op;
        t_pos_op  pos_op;
        t_idx_op  idx_op;
        t_emit    emit;
    } t_ctl;

    localparam t_ctl CTL_NOP = '0;

    typedef struct packed {
        logic in_valid;
        logic eol;
        logic cancel;
        logic kill;
        logic bs;
        logic storable;
        logic fill_zero;
        logic scan_end;
        logic pos_end;
        logic space;
        logic idx_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== design/line_editor_tokenizer.sv =====
`default_nettype none

// Line editor for a character terminal. One received byte is taken per request on the
// input channel (i_in_valid / o_in_ready, i_char_code); results leave on the output
// channel (o_out_valid / i_out_ready) through a single output register.
// Printable bytes are stored and echoed while the 127-entry line has room, backspace
// and 0x7F give an erase result while the line is not empty, 0x03 a cancel result, CR
// or LF a line-end result with the token count followed by one result per token (up to
// 8). o_last marks the final result of a request. Other bytes give nothing.
// A small microprogram steps a shared datapath; o_in_ready is high only in its idle step.
// Editing bytes: the result is registered in the program's emitting step, and the next
// request is taken only once the program is back in its idle step.
// Line end: the token scan reads the store once per stored character it passes (a test,
// a check and an advance step each), then the line result and the token results follow.
// When the receiver stalls, the program holds at its emitting step until the output
// register is free; a request may be taken while the last result still waits.
// Reset (synchronous, active low) empties the line and the output register; the line
// store itself is not cleared.
module line_editor_tokenizer import ledt_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [CHAR_W-1:0]   i_char_code,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic      [KIND_W-1:0]   o_kind,
    output logic      [CHAR_W-1:0]   o_echo_char,
    output logic      [ERASE_W-1:0]  o_erase_count,
    output logic      [TCOUNT_W-1:0] o_token_count,
    output logic      [TINDEX_W-1:0] o_token_index,
    output logic      [TSTART_W-1:0] o_token_start,
    output logic      [TLEN_W-1:0]   o_token_length,
    output logic                     o_last
);

    t_ctl    ctl;
    t_status status;

    ledt_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctl    (ctl)
    );

    ledt_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_ctl          (ctl),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_echo_char    (o_echo_char),
        .o_erase_count  (o_erase_count),
        .o_token_count  (o_token_count),
        .o_token_index  (o_token_index),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// ===== design/ledt_ram.sv =====
`default_nettype none

module ledt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 127,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/ledt_datapath.sv =====
`default_nettype none

module ledt_datapath import ledt_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [CHAR_W-1:0]   i_char_code,
    input  wire t_ctl                i_ctl,
    output t_status                  o_status,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic      [KIND_W-1:0]   o_kind,
    output logic      [CHAR_W-1:0]   o_echo_char,
    output logic      [ERASE_W-1:0]  o_erase_count,
    output logic      [TCOUNT_W-1:0] o_token_count,
    output logic      [TINDEX_W-1:0] o_token_index,
    output logic      [TSTART_W-1:0] o_token_start,
    output logic      [TLEN_W-1:0]   o_token_length,
    output logic                     o_last
);

    logic [CHAR_W-1:0]  r_char;
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  r_pos;
    logic [FILL_W-1:0]  r_start;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_idx;
    logic [FILL_W-1:0]  r_starts [MAX_TOKENS];
    logic [FILL_W-1:0]  r_lens   [MAX_TOKENS];
    logic               r_out_valid;

    logic [KIND_W-1:0]   r_kind,   n_kind;
    logic [CHAR_W-1:0]   r_echo,   n_echo;
    logic [ERASE_W-1:0]  r_erase,  n_erase;
    logic [TCOUNT_W-1:0] r_tcount, n_tcount;
    logic [TINDEX_W-1:0] r_tindex, n_tindex;
    logic [TSTART_W-1:0] r_tstart, n_tstart;
    logic [TLEN_W-1:0]   r_tlen,   n_tlen;
    logic                r_last,   n_last;

    logic              out_free;
    logic              go;
    logic              accept;
    logic              emit_go;
    logic [CHAR_W-1:0] rd_data;

    assign out_free = !r_out_valid || i_out_ready;
    // a step that emits waits here until the output register has room
    assign go       = !((i_ctl.emit != E_NONE) && !out_free);
    assign accept   = i_ctl.in_ready && i_in_valid;
    assign emit_go  = go && (i_ctl.emit != E_NONE);

    ledt_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (go && i_ctl.wr_en),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (r_char),
        .i_raddr (r_pos[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_kind   = K_ECHO;
        n_echo   = '0;
        n_erase  = '0;
        n_tcount = '0;
        n_tindex = '0;
        n_tstart = '0;
        n_tlen   = '0;
        n_last   = 1'b1;
        case (i_ctl.emit)
            E_ECHO: begin
                n_kind = K_ECHO;
                n_echo = r_char;
            end
            E_KILL: begin
                n_kind  = K_ERASE;
                n_erase = ERASE_W'(r_fill);
            end
            E_BS: begin
                n_kind  = K_ERASE;
                n_erase = ERASE_W'(1);
            end
            E_CANCEL: begin
                n_kind = K_CANCEL;
            end
            E_LINE: begin
                n_kind   = K_LINE;
                n_tcount = TCOUNT_W'(r_count);
                n_last   = (r_count == '0);
            end
            E_TOKEN: begin
                n_kind   = K_TOKEN;
                n_tindex = TINDEX_W'(r_idx[IDX_W-1:0]);
                n_tstart = TSTART_W'(r_starts[r_idx[IDX_W-1:0]]);
                n_tlen   = TLEN_W'(r_lens[r_idx[IDX_W-1:0]]);
                n_last   = ((r_idx + COUNT_W'(1)) == r_count);
            end
            default: begin
                n_kind = K_ECHO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (go) begin
                case (i_ctl.fill_op)
                    F_INC:   r_fill <= r_fill + FILL_W'(1);
                    F_DEC:   r_fill <= r_fill - FILL_W'(1);
                    F_CLR:   r_fill <= '0;
                    default: r_fill <= r_fill;
                endcase
                case (i_ctl.pos_op)
                    P_CLR:   r_pos <= '0;
                    P_INC:   r_pos <= r_pos + FILL_W'(1);
                    default: r_pos <= r_pos;
                endcase
                case (i_ctl.idx_op)
                    I_CLR:   r_idx <= '0;
                    I_INC:   r_idx <= r_idx + COUNT_W'(1);
                    default: r_idx <= r_idx;
                endcase
                if (i_ctl.scan_clr) begin
                    r_count <= '0;
                end else if (i_ctl.tok_save) begin
                    r_count <= r_count + COUNT_W'(1);
                end
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= i_char_code;
        end
        if (go && i_ctl.tok_start) begin
            r_start <= r_pos;
        end
        if (go && i_ctl.tok_save) begin
            r_starts[r_count[IDX_W-1:0]] <= r_start;
            r_lens[r_count[IDX_W-1:0]]   <= r_pos - r_start;
        end
        if (emit_go) begin
            r_kind   <= n_kind;
            r_echo   <= n_echo;
            r_erase  <= n_erase;
            r_tcount <= n_tcount;
            r_tindex <= n_tindex;
            r_tstart <= n_tstart;
            r_tlen   <= n_tlen;
            r_last   <= n_last;
        end
    end

    always_comb begin
        o_status.in_valid  = i_in_valid;
        o_status.eol       = (r_char == CH_LF) || (r_char == CH_CR);
        o_status.cancel    = (r_char == CH_ETX);
        o_status.kill      = (r_char == CH_DEL);
        o_status.bs        = (r_char == CH_BS);
        o_status.storable  = (r_char >= CH_SPACE) && (r_char <= CH_TILDE)
                             && (r_fill < FILL_W'(LINE_CAPACITY));
        o_status.fill_zero = (r_fill == '0);
        o_status.scan_end  = (r_pos >= r_fill) || (r_count >= COUNT_W'(MAX_TOKENS));
        o_status.pos_end   = (r_pos >= r_fill);
        o_status.space     = (rd_data == CH_SPACE);
        o_status.idx_done  = (r_idx == r_count);
        o_status.out_free  = out_free;
    end

    assign o_in_ready     = i_ctl.in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_echo_char    = r_echo;
    assign o_erase_count  = r_erase;
    assign o_token_count  = r_tcount;
    assign o_token_index  = r_tindex;
    assign o_token_start  = r_tstart;
    assign o_token_length = r_tlen;
    assign o_last         = r_last;

    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(LINE_CAPACITY))
        else $error("fill count above line capacity");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(MAX_TOKENS))
        else $error("token count above limit");

    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && i_ctl.wr_en) |-> (r_fill < FILL_W'(LINE_CAPACITY)))
        else $error("store write with full line");

    a_token_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_go && (i_ctl.emit == E_TOKEN)) |-> (r_idx < r_count))
        else $error("token request beyond token count");

endmodule

`default_nettype wire

// ===== design/ledt_seq.sv =====
`default_nettype none

module ledt_seq import ledt_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_status i_status,
    output t_ctl         o_ctl
);

    typedef enum logic [4:0] {
        S_IDLE       = 5'd0,
        S_D_EOL      = 5'd1,
        S_D_CAN      = 5'd2,
        S_D_KILL     = 5'd3,
        S_D_BS       = 5'd4,
        S_D_PR       = 5'd5,
        S_ECHO       = 5'd6,
        S_CANCEL     = 5'd7,
        S_KILL       = 5'd8,
        S_KILL_EMIT  = 5'd9,
        S_BS         = 5'd10,
        S_BS_EMIT    = 5'd11,
        S_SCAN_INIT  = 5'd12,
        S_SCAN_TEST  = 5'd13,
        S_SCAN_CHK   = 5'd14,
        S_TOK_BEGIN  = 5'd15,
        S_TOK_TEST   = 5'd16,
        S_TOK_CHK    = 5'd17,
        S_TOK_NEXT   = 5'd18,
        S_TOK_END    = 5'd19,
        S_SKIP       = 5'd20,
        S_EMIT_LINE  = 5'd21,
        S_EMIT_TEST  = 5'd22,
        S_EMIT_TOK   = 5'd23
    } t_step;

    typedef struct packed {
        t_cond cond;
        t_step target;
        t_ctl  ctl;
    } t_uword;

    t_step  r_pc;
    t_step  n_pc;
    t_uword w;
    logic   take;
    logic   hold;

    // microcode table
    always_comb begin
        w.cond   = C_NEXT;
        w.target = S_IDLE;
        w.ctl    = CTL_NOP;
        unique case (r_pc)
            S_IDLE: begin
                w.ctl.in_ready = 1'b1;
                w.cond         = C_NO_INPUT;
                w.target       = S_IDLE;
            end
            S_D_EOL: begin
                w.cond   = C_EOL;
                w.target = S_SCAN_INIT;
            end
            S_D_CAN: begin
                w.cond   = C_CANCEL;
                w.target = S_CANCEL;
            end
            S_D_KILL: begin
                w.cond   = C_KILL;
                w.target = S_KILL;
            end
            S_D_BS: begin
                w.cond   = C_BS;
                w.target = S_BS;
            end
            S_D_PR: begin
                w.cond   = C_NOT_STORABLE;
                w.target = S_IDLE;
            end
            S_ECHO: begin
                w.ctl.wr_en   = 1'b1;
                w.ctl.fill_op = F_INC;
                w.ctl.emit    = E_ECHO;
                w.cond        = C_ALWAYS;
            end
            S_CANCEL: begin
                w.ctl.fill_op = F_CLR;
                w.ctl.emit    = E_CANCEL;
                w.cond        = C_ALWAYS;
            end
            S_KILL: begin
                w.cond = C_FILL_ZERO;
            end
            S_KILL_EMIT: begin
                w.ctl.fill_op = F_CLR;
                w.ctl.emit    = E_KILL;
                w.cond        = C_ALWAYS;
            end
            S_BS: begin
                w.cond = C_FILL_ZERO;
            end
            S_BS_EMIT: begin
                w.ctl.fill_op = F_DEC;
                w.ctl.emit    = E_BS;
                w.cond        = C_ALWAYS;
            end
            S_SCAN_INIT: begin
                w.ctl.pos_op   = P_CLR;
                w.ctl.scan_clr = 1'b1;
            end
            // store read at the current position lands in the next step
            S_SCAN_TEST: begin
                w.cond   = C_SCAN_END;
                w.target = S_EMIT_LINE;
            end
            S_SCAN_CHK: begin
                w.cond   = C_SPACE;
                w.target = S_SKIP;
            end
            S_TOK_BEGIN: begin
                w.ctl.tok_start = 1'b1;
                w.ctl.pos_op    = P_INC;
            end
            S_TOK_TEST: begin
                w.cond   = C_POS_END;
                w.target = S_TOK_END;
            end
            S_TOK_CHK: begin
                w.cond   = C_SPACE;
                w.target = S_TOK_END;
            end
            S_TOK_NEXT: begin
                w.ctl.pos_op = P_INC;
                w.cond       = C_ALWAYS;
                w.target     = S_TOK_TEST;
            end
            S_TOK_END: begin
                w.ctl.tok_save = 1'b1;
                w.cond         = C_ALWAYS;
                w.target       = S_SCAN_TEST;
            end
            S_SKIP: begin
                w.ctl.pos_op = P_INC;
                w.cond       = C_ALWAYS;
                w.target     = S_SCAN_TEST;
            end
            S_EMIT_LINE: begin
                w.ctl.emit    = E_LINE;
                w.ctl.fill_op = F_CLR;
                w.ctl.idx_op  = I_CLR;
            end
            S_EMIT_TEST: begin
                w.cond   = C_IDX_DONE;
                w.target = S_IDLE;
            end
            S_EMIT_TOK: begin
                w.ctl.emit   = E_TOKEN;
                w.ctl.idx_op = I_INC;
                w.cond       = C_ALWAYS;
                w.target     = S_EMIT_TEST;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
    end

    always_comb begin
        unique case (w.cond)
            C_NEXT:         take = 1'b0;
            C_ALWAYS:       take = 1'b1;
            C_NO_INPUT:     take = !i_status.in_valid;
            C_EOL:          take = i_status.eol;
            C_CANCEL:       take = i_status.cancel;
            C_KILL:         take = i_status.kill;
            C_BS:           take = i_status.bs;
            C_NOT_STORABLE: take = !i_status.storable;
            C_FILL_ZERO:    take = i_status.fill_zero;
            C_SCAN_END:     take = i_status.scan_end;
            C_SPACE:        take = i_status.space;
            C_POS_END:      take = i_status.pos_end;
            C_IDX_DONE:     take = i_status.idx_done;
            default:        take = 1'b0;
        endcase
    end

    assign hold = (w.ctl.emit != E_NONE) && !i_status.out_free;

    always_comb begin
        if (hold) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = w.target;
        end else begin
            n_pc = t_step'(r_pc + 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl = w.ctl;

endmodule

`default_nettype wire
